@@ hdl/tdrsi_pkg.sv @@
// shared types, constants and helpers of the tdr step-to-impedance converter
`timescale 1ns / 1ps
package tdrsi_pkg;

  // record head used for the baseline
  localparam int BASE_LEN = 64;
  localparam int CNT_W    = $clog2(BASE_LEN + 1);
  localparam int IDX_W    = (BASE_LEN > 1) ? $clog2(BASE_LEN) : 1;

  // datapath widths
  localparam int SMP_W  = 32;
  localparam int SUM_W  = 48;
  localparam int ACC_W  = SUM_W + CNT_W;
  localparam int IT_W   = $clog2(ACC_W);
  localparam int G_W    = 32;
  localparam int Z_W    = 16;
  localparam int IMP_W  = 28;
  localparam int FAC_W  = 31;
  localparam int NUM_W  = Z_W + FAC_W;
  localparam int QIT_W  = $clog2(IMP_W);

  // q.30 constants
  localparam logic signed [G_W-1:0] ONE_Q30   = 32'sd1073741824;
  localparam logic signed [G_W-1:0] CLAMP_Q30 = 32'sd1072668082;

  // configuration port
  localparam int            CFG_AW  = 3;
  localparam logic          REG_Z0  = 1'b0;
  localparam logic [Z_W-1:0] Z0_RESET = 16'd12800;

  // job queue
  localparam int Q_DEPTH = 4;
  localparam int QP_W    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic signed [G_W-1:0] g;
    logic                  last;
  } job_t;

  typedef enum logic [1:0] {F_RUN, F_DIV, F_ADDR, F_DATA} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV, B_HOLD} back_state_t;

  // baseline-corrected reflection, clamped to +/-0.999
  function automatic logic signed [G_W-1:0] clamp_g(input logic signed [SUM_W-1:0] step,
                                                    input logic signed [SUM_W-1:0] base);
    logic signed [SUM_W:0] d;
    d = {step[SUM_W-1], step} - {base[SUM_W-1], base};
    if (d > (SUM_W+1)'(CLAMP_Q30)) return CLAMP_Q30;
    else if (d < -(SUM_W+1)'(CLAMP_Q30)) return -CLAMP_Q30;
    else return d[G_W-1:0];
  endfunction

endpackage

@@ hdl/tdrsi_if.sv @@
// stream interfaces for sample and result words
`timescale 1ns / 1ps
interface tdrsi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] impulse_sample;
  logic               last_sample;
  modport source (output valid, impulse_sample, last_sample, input ready);
  modport sink (input valid, impulse_sample, last_sample, output ready);
endinterface

interface tdrsi_out_if;
  logic        valid;
  logic        ready;
  logic [27:0] impedance;
  logic        last_result;
  modport source (output valid, impedance, last_result, input ready);
  modport sink (input valid, impedance, last_result, output ready);
endinterface

@@ hdl/tdrsi_ram.sv @@
// generic single-write ram with registered read
`timescale 1ns / 1ps
module tdrsi_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ hdl/tdrsi_fifo.sv @@
// short job queue between front and back
`timescale 1ns / 1ps
module tdrsi_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tdrsi_pkg::job_t  push_job,
  output logic             full,
  output logic             job_valid,
  output tdrsi_pkg::job_t  job,
  input  logic             take
);
  import tdrsi_pkg::*;

  job_t          slots [Q_DEPTH];
  logic [QP_W-1:0] wptr;
  logic [QP_W-1:0] rptr;
  logic [QP_W:0]   count;

  assign full      = (count == (QP_W+1)'(Q_DEPTH));
  assign job_valid = (count != '0);
  assign job       = slots[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_job;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (take) rptr <= rptr + 1'b1;
      if (push && !take) count <= count + 1'b1;
      else if (take && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) take |-> job_valid)
    else $error("queue take while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
      (push && !take) |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance");

endmodule

@@ hdl/tdrsi_front.sv @@
// front: running sum, head buffering, baseline mean and replay into the job queue
`timescale 1ns / 1ps
module tdrsi_front (
  input  logic            clk,
  input  logic            rst,
  tdrsi_in_if.sink        samples,
  output logic            push,
  output tdrsi_pkg::job_t push_job,
  input  logic            full
);
  import tdrsi_pkg::*;

  front_state_t            state, state_next;
  logic signed [SUM_W-1:0] running_sum;
  logic [CNT_W-1:0]        head_count;
  logic signed [ACC_W-1:0] head_sum;
  logic signed [SUM_W-1:0] baseline;
  logic                    known;
  logic                    rec_last;
  logic [ACC_W-1:0]        dq;
  logic [CNT_W-1:0]        rem;
  logic                    neg;
  logic [IT_W-1:0]         iter;
  logic [CNT_W-1:0]        idx;

  logic                    accept;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [ACC_W-1:0] acc_new;
  logic [CNT_W:0]          rem_sh;
  logic [CNT_W:0]          rem_try;
  logic                    ge;
  logic [ACC_W-1:0]        quot;
  logic                    last_entry;
  logic                    we;
  logic                    re;
  logic [SUM_W-1:0]        rdata;

  assign samples.ready = (state == F_RUN) && !full;
  assign accept        = samples.valid && samples.ready;
  assign sum_next      = running_sum + SUM_W'(samples.impulse_sample);
  assign acc_new       = head_sum + ACC_W'(sum_next);
  assign last_entry    = (idx == head_count - CNT_W'(1));

  // one bit of the baseline mean per cycle
  assign rem_sh  = {rem, dq[ACC_W-1]};
  assign rem_try = rem_sh - {1'b0, head_count};
  assign ge      = !rem_try[CNT_W];
  assign quot    = {dq[ACC_W-2:0], ge};

  tdrsi_ram #(.WIDTH(SUM_W), .DEPTH(BASE_LEN)) u_head (
    .clk   (clk),
    .we    (we),
    .waddr (head_count[IDX_W-1:0]),
    .wdata (sum_next),
    .re    (re),
    .raddr (idx[IDX_W-1:0]),
    .rdata (rdata)
  );

  // next state and outputs
  always_comb begin
    state_next = state;
    push       = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    push_job   = '{g: clamp_g(sum_next, baseline), last: samples.last_sample};
    unique case (state)
      F_RUN: begin
        if (accept) begin
          if (known) begin
            push = 1'b1;
          end else begin
            we = 1'b1;
            if (head_count == CNT_W'(BASE_LEN - 1) || samples.last_sample) state_next = F_DIV;
          end
        end
      end
      F_DIV: begin
        if (iter == IT_W'(ACC_W - 1)) state_next = F_ADDR;
      end
      F_ADDR: begin
        re         = 1'b1;
        state_next = F_DATA;
      end
      F_DATA: begin
        push_job = '{g: clamp_g(rdata, baseline), last: rec_last && last_entry};
        if (!full) begin
          push       = 1'b1;
          state_next = last_entry ? F_RUN : F_ADDR;
        end
      end
      default: state_next = F_RUN;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= F_RUN;
    else state <= state_next;
  end

  // record state and divider
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      head_count  <= '0;
      head_sum    <= '0;
      baseline    <= '0;
      known       <= 1'b0;
      rec_last    <= 1'b0;
      iter        <= '0;
      idx         <= '0;
    end else begin
      unique case (state)
        F_RUN: begin
          if (accept) begin
            running_sum <= samples.last_sample ? '0 : sum_next;
            if (known) begin
              if (samples.last_sample) begin
                known      <= 1'b0;
                baseline   <= '0;
                head_count <= '0;
              end
            end else begin
              head_count <= head_count + 1'b1;
              head_sum   <= acc_new;
              rec_last   <= samples.last_sample;
              dq         <= acc_new[ACC_W-1] ? ACC_W'(-acc_new) : ACC_W'(acc_new);
              neg        <= acc_new[ACC_W-1];
              rem        <= '0;
              iter       <= '0;
            end
          end
        end
        F_DIV: begin
          dq   <= quot;
          rem  <= ge ? rem_try[CNT_W-1:0] : rem_sh[CNT_W-1:0];
          iter <= iter + 1'b1;
          if (iter == IT_W'(ACC_W - 1)) begin
            baseline <= neg ? -SUM_W'(quot) : SUM_W'(quot);
            known    <= 1'b1;
            idx      <= '0;
            head_sum <= '0;
          end
        end
        F_ADDR: ;
        F_DATA: begin
          if (!full) begin
            idx <= idx + 1'b1;
            if (last_entry && rec_last) begin
              known      <= 1'b0;
              baseline   <= '0;
              head_count <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_ready_in_run: assert property (@(posedge clk) disable iff (rst)
      samples.ready |-> state == F_RUN)
    else $error("sample taken outside run state");
  a_head_bound: assert property (@(posedge clk) disable iff (rst)
      head_count <= CNT_W'(BASE_LEN))
    else $error("head count beyond buffer");
  a_mean_done: assert property (@(posedge clk) disable iff (rst)
      (state == F_DIV && iter == IT_W'(ACC_W - 1)) |=> known && state == F_ADDR)
    else $error("baseline not published after mean");

endmodule

@@ hdl/tdrsi_back.sv @@
// back: impedance z0*(1+g)/(1-g) by one multiply and a bit-serial divide
`timescale 1ns / 1ps
module tdrsi_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      job_valid,
  input  tdrsi_pkg::job_t           job,
  output logic                      job_take,
  input  logic [tdrsi_pkg::Z_W-1:0] z0,
  tdrsi_out_if.source               results
);
  import tdrsi_pkg::*;

  back_state_t           state, state_next;
  logic signed [G_W-1:0] g;
  logic                  last;
  logic [FAC_W-1:0]      den;
  logic [FAC_W-1:0]      rem;
  logic [IMP_W-1:0]      dq;
  logic [QIT_W-1:0]      cnt;
  logic                  oval;
  logic [IMP_W-1:0]      oimp;
  logic                  olast;

  logic [G_W-1:0]        fac_num;
  logic [G_W-1:0]        fac_den;
  logic [NUM_W-1:0]      prod;
  logic [FAC_W:0]        rem_sh;
  logic [FAC_W+1:0]      rem_try;
  logic                  ge;
  logic                  out_free;

  assign fac_num  = G_W'(ONE_Q30 + g);
  assign fac_den  = G_W'(ONE_Q30 - g);
  assign prod     = NUM_W'(z0) * NUM_W'(fac_num[FAC_W-1:0]);
  assign rem_sh   = {rem, dq[IMP_W-1]};
  assign rem_try  = {1'b0, rem_sh} - {2'b00, den};
  assign ge       = !rem_try[FAC_W+1];
  assign out_free = !oval || results.ready;

  assign results.valid       = oval;
  assign results.impedance   = oimp;
  assign results.last_result = olast;

  // next state
  always_comb begin
    state_next = state;
    job_take   = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (job_valid) begin
          job_take   = 1'b1;
          state_next = B_MUL;
        end
      end
      B_MUL: state_next = B_DIV;
      B_DIV: if (cnt == QIT_W'(IMP_W - 1)) state_next = B_HOLD;
      B_HOLD: if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        g    <= job.g;
        last <= job.last;
      end
      B_MUL: begin
        // quotient stays below 2^28, so the top bits start as the remainder
        rem <= FAC_W'(prod[NUM_W-1:IMP_W]);
        dq  <= prod[IMP_W-1:0];
        den <= fac_den[FAC_W-1:0];
        cnt <= '0;
      end
      B_DIV: begin
        rem <= ge ? rem_try[FAC_W-1:0] : rem_sh[FAC_W-1:0];
        dq  <= {dq[IMP_W-2:0], ge};
        cnt <= cnt + 1'b1;
      end
      B_HOLD: ;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      oval <= 1'b0;
    end else if (state == B_HOLD && out_free) begin
      oval  <= 1'b1;
      oimp  <= dq;
      olast <= last;
    end else if (results.ready) begin
      oval <= 1'b0;
    end
  end

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
      job_take |-> state == B_IDLE && job_valid)
    else $error("job taken while busy");
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
      state == B_DIV |-> den != '0)
    else $error("zero divisor");
  a_div_ends: assert property (@(posedge clk) disable iff (rst)
      (state == B_DIV && cnt == QIT_W'(IMP_W - 1)) |=> state == B_HOLD)
    else $error("divide did not finish");

endmodule

@@ hdl/tdr_step_to_impedance_core.sv @@
// tdr step-to-impedance converter top level with apb register port
// once the baseline is known, each sample word goes via the job queue to the back divider
// the back takes a new word only after its 28-step quotient loop and output hold are done
// head of a record: baseline mean first, then replay of each buffered word (address, data)
// reset: rst clears record state, queue and output; reference impedance returns to 12800
// the head buffer ram is not cleared: only entries written in the current record are read
`timescale 1ns / 1ps
module tdr_step_to_impedance_core (
  input  logic                         clk,
  input  logic                         rst,
  tdrsi_in_if.sink                     samples,
  tdrsi_out_if.source                  results,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tdrsi_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import tdrsi_pkg::*;

  logic [Z_W-1:0] z0;
  logic           push;
  job_t           push_job;
  logic           full;
  logic           job_valid;
  job_t           job;
  logic           job_take;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[CFG_AW-1] == REG_Z0) ? 32'(z0) : '0;

  always_ff @(posedge clk) begin
    if (rst) z0 <= Z0_RESET;
    else if (psel && penable && pwrite && pready && paddr[CFG_AW-1] == REG_Z0)
      z0 <= pwdata[Z_W-1:0];
  end

  tdrsi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  tdrsi_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .job_valid (job_valid),
    .job       (job),
    .take      (job_take)
  );

  tdrsi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .z0        (z0),
    .results   (results)
  );

endmodule
